[src/assert_macros.svh]
// Assertion helpers for the list logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define OL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define OL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ol_pkg.sv]
package ol_pkg;

  // Operation codes on the opcode port
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_TOP    = 3'd1;
  localparam logic [2:0] OP_BOTTOM = 3'd2;
  localparam logic [2:0] OP_UP     = 3'd3;
  localparam logic [2:0] OP_DOWN   = 3'd4;
  localparam logic [2:0] OP_ASK    = 3'd5;
  localparam logic [2:0] OP_QUERY  = 3'd6;

  // Status codes on the status port
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_BADPOS  = 3'd3;
  localparam logic [2:0] ST_NONEIGH = 3'd4;
  localparam logic [2:0] ST_DUP     = 3'd5;

  // Update broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_APPEND,
    CMD_TOP,
    CMD_BOTTOM,
    CMD_UP,
    CMD_DOWN
  } ol_cmd_t;

  typedef struct packed {
    ol_cmd_t    cmd;
    logic [7:0] key;
  } ol_ctl_t;

endpackage

[src/ordered_id_list_reorder_top.sv]
// Channel   Handshake          Ports
// command   start, busy        opcode, item_id, position
// result    done (one cycle)   answer, status
//
// busy is high after a word is taken, through S_FIND, which matches the key across the
// cell chain and encodes its slot, and S_EXEC, which updates the cells and registers the
// result. done is high in the cycle after S_EXEC, with busy low; a new start is taken at
// its end, so a new word is not taken before the last one's result has been shown.
// Synchronous reset empties the list; the cell contents are not cleared.
// The receiver cannot stall: each result shows for exactly one cycle.
module ordered_id_list_reorder_top
  import ol_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] opcode,
  input  logic [7:0] item_id,
  input  logic [8:0] position,
  output logic       done,
  output logic [8:0] answer,
  output logic [2:0] status
);

`include "assert_macros.svh"

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = IW + 1;
  localparam int PW = IW + 10;
  localparam logic [LW-1:0] FULL_LEN = LW'(SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_FIND, S_EXEC} state_t;

  state_t        state;
  logic [2:0]    op_r;
  logic [7:0]    id_r;
  logic [8:0]    pos_r;
  logic [LW-1:0] length;
  logic [IW-1:0] idx_r;
  logic          found_r;
  logic [7:0]    qval_r;
  logic          posok_r;

  logic [SLOTS-1:0] match;
  logic [7:0]       vals [SLOTS];
  logic [IW-1:0]    idx_f;
  logic             found_f;
  logic [7:0]       qval_f;
  logic [PW-1:0]    pos_w;
  logic [PW-1:0]    len_w;
  logic [PW-1:0]    sel_w;
  logic             pos_ok;
  logic [PW-1:0]    idx_wide;
  ol_ctl_t          ctl;
  logic [8:0]       answer_next;
  logic [2:0]       status_next;

  assign busy = (state != S_IDLE);

  // Check the query position against the list length
  assign pos_w  = {{(PW-9){1'b0}}, pos_r};
  assign len_w  = {{(PW-LW){1'b0}}, length};
  assign sel_w  = pos_w - 1'b1;
  assign pos_ok = (pos_r != '0) && (pos_w <= len_w);

  // Build the chain of cells, each wired to its neighbors
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic [7:0] left_v;
    logic [7:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = id_r;
    end else begin : g_mid
      assign left_v = vals[g-1];
    end
    if (g == SLOTS - 1) begin : g_last
      assign right_v = id_r;
    end else begin : g_inner
      assign right_v = vals[g+1];
    end
    ol_cell #(.IW(IW), .IDX(g)) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .idx    (idx_r),
      .length (length),
      .left   (left_v),
      .right  (right_v),
      .value  (vals[g]),
      .match  (match[g])
    );
  end

  ol_find #(.SLOTS(SLOTS), .IW(IW)) u_find (
    .match (match),
    .vals  (vals),
    .sel   (sel_w[IW-1:0]),
    .idx   (idx_f),
    .found (found_f),
    .qval  (qval_f)
  );

  assign idx_wide = {{(PW-IW){1'b0}}, idx_r};

  // Decode the operation into a cell update and a result
  always_comb begin
    ctl.key     = id_r;
    ctl.cmd     = CMD_NONE;
    answer_next = '0;
    status_next = ST_OK;
    if (state == S_EXEC) begin
      unique case (op_r)
        OP_APPEND: begin
          if (found_r) status_next = ST_DUP;
          else if (length == FULL_LEN) status_next = ST_FULL;
          else ctl.cmd = CMD_APPEND;
        end
        OP_TOP: begin
          if (!found_r) status_next = ST_UNKNOWN;
          else ctl.cmd = CMD_TOP;
        end
        OP_BOTTOM: begin
          if (!found_r) status_next = ST_UNKNOWN;
          else ctl.cmd = CMD_BOTTOM;
        end
        OP_UP: begin
          if (!found_r) status_next = ST_UNKNOWN;
          else if (idx_r == '0) status_next = ST_NONEIGH;
          else ctl.cmd = CMD_UP;
        end
        OP_DOWN: begin
          if (!found_r) status_next = ST_UNKNOWN;
          else if (({1'b0, idx_r} + 1'b1) >= length) status_next = ST_NONEIGH;
          else ctl.cmd = CMD_DOWN;
        end
        OP_ASK: begin
          if (!found_r) status_next = ST_UNKNOWN;
          else answer_next = idx_wide[8:0];
        end
        OP_QUERY: begin
          if (!posok_r) status_next = ST_BADPOS;
          else answer_next = {1'b0, qval_r};
        end
        default: begin
          ctl.cmd = CMD_NONE;
        end
      endcase
    end
  end

  // Hold state, operands, list length and the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      length <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r  <= opcode;
            id_r  <= item_id;
            pos_r <= position;
            state <= S_FIND;
          end
        end
        S_FIND: begin
          idx_r   <= idx_f;
          found_r <= found_f;
          qval_r  <= qval_f;
          posok_r <= pos_ok;
          state   <= S_EXEC;
        end
        S_EXEC: begin
          answer <= answer_next;
          status <= status_next;
          done   <= 1'b1;
          if (ctl.cmd == CMD_APPEND) length <= length + 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OL_ASSERT(a_done_not_busy, !(done && busy), "result strobe while busy")
  `OL_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not set busy")
  `OL_ASSERT(a_len_bound, length <= FULL_LEN, "list length above slot count")
  `OL_ASSERT(a_match_unique, $onehot0(match), "key matched more than one slot")
  `OL_ASSERT_NEXT(a_len_hold, state == S_EXEC && ctl.cmd != CMD_APPEND, $stable(length),
    "length changed without an append")

endmodule

[src/ol_cell.sv]
module ol_cell
  import ol_pkg::*;
#(
  parameter int IW  = 8,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  ol_ctl_t       ctl,
  input  logic [IW-1:0] idx,
  input  logic [IW:0]   length,
  input  logic [7:0]    left,
  input  logic [7:0]    right,
  output logic [7:0]    value,
  output logic          match
);

  localparam logic [IW:0] ME  = (IW+1)'(IDX);
  localparam logic [IW:0] ME1 = (IW+1)'(IDX + 1);

  logic [IW:0] idx_w;
  logic [IW:0] last;
  logic [7:0]  value_next;

  assign idx_w = {1'b0, idx};
  assign last  = length - 1'b1;

  // Flag this slot when it is in use and holds the key
  assign match = (ME < length) && (value == ctl.key);

  // Pick the new word: keep, take the key, or take a neighbor
  always_comb begin
    value_next = value;
    case (ctl.cmd)
      CMD_APPEND: begin
        if (ME == length) value_next = ctl.key;
      end
      CMD_TOP: begin
        if (ME == '0) value_next = ctl.key;
        else if (ME <= idx_w) value_next = left;
      end
      CMD_BOTTOM: begin
        if (ME == last) value_next = ctl.key;
        else if (ME >= idx_w && ME < last) value_next = right;
      end
      CMD_UP: begin
        if (ME1 == idx_w) value_next = ctl.key;
        else if (ME == idx_w) value_next = left;
      end
      CMD_DOWN: begin
        if (ME == idx_w + 1'b1) value_next = ctl.key;
        else if (ME == idx_w) value_next = right;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

[src/ol_find.sv]
module ol_find
  import ol_pkg::*;
#(
  parameter int SLOTS = 256,
  parameter int IW    = 8
) (
  input  logic [SLOTS-1:0] match,
  input  logic [7:0]       vals [SLOTS],
  input  logic [IW-1:0]    sel,
  output logic [IW-1:0]    idx,
  output logic             found,
  output logic [7:0]       qval
);

  // Encode the single matching slot into its index
  always_comb begin
    idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match[i]) idx = idx | IW'(i);
    end
  end

  assign found = |match;

  // Select the word at the queried slot
  always_comb begin
    qval = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel == IW'(i)) qval = qval | vals[i];
    end
  end

endmodule
